// ----- rtl/core/lpd_pkg.sv -----
// ----------------------------------------------------------------------------
// lpd_pkg
// Shared types and constants for the length-prefix deframer.
// ----------------------------------------------------------------------------
package lpd_pkg;

    localparam int DEFAULT_MAX_FRAME_BYTES = 2048;
    localparam int LEN_W                   = 32;
    localparam int FLEN_W                  = 11;

    typedef enum logic [1:0] {
        ST_HEADER  = 2'd0,
        ST_PAYLOAD = 2'd1,
        ST_BADLEN  = 2'd2,
        ST_REJECT  = 2'd3
    } lpd_status_t;

    typedef struct packed {
        lpd_status_t       status;
        logic [7:0]        payload_byte;
        logic              last;
        logic [FLEN_W-1:0] frame_length;
    } lpd_result_t;

endpackage

// ----- rtl/core/lpd_decoder.sv -----
// ----------------------------------------------------------------------------
// lpd_decoder
// Header/payload state and the per-word result logic.
// ----------------------------------------------------------------------------
module lpd_decoder #(
    parameter int MAX_FRAME_BYTES = lpd_pkg::DEFAULT_MAX_FRAME_BYTES
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                accept,
    input  logic                kind,
    input  logic [7:0]          data_byte,
    output lpd_pkg::lpd_result_t result
);

    localparam int REM_W = $clog2(MAX_FRAME_BYTES);
    localparam logic [lpd_pkg::LEN_W-1:0] LEN_LIMIT =
        lpd_pkg::LEN_W'(MAX_FRAME_BYTES - 4);
    localparam logic [REM_W-1:0] REM_ONE = REM_W'(1);

    logic [1:0]                header_count_reg, header_count_next;
    logic [lpd_pkg::LEN_W-1:0] length_shift_reg, length_shift_next;
    logic [REM_W-1:0]          payload_remaining_reg, payload_remaining_next;
    logic                      error_flag_reg, error_flag_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_count_reg      <= '0;
            length_shift_reg      <= '0;
            payload_remaining_reg <= '0;
            error_flag_reg        <= 1'b0;
        end else if (accept) begin
            header_count_reg      <= header_count_next;
            length_shift_reg      <= length_shift_next;
            payload_remaining_reg <= payload_remaining_next;
            error_flag_reg        <= error_flag_next;
        end
    end

    always_comb begin
        header_count_next      = header_count_reg;
        length_shift_next      = length_shift_reg;
        payload_remaining_next = payload_remaining_reg;
        error_flag_next        = error_flag_reg;
        result.status          = lpd_pkg::ST_HEADER;
        result.payload_byte    = '0;
        result.last            = 1'b0;
        result.frame_length    = '0;

        if (kind) begin
            header_count_next      = '0;
            length_shift_next      = '0;
            payload_remaining_next = '0;
            error_flag_next        = 1'b0;
        end else if (error_flag_reg) begin
            result.status = lpd_pkg::ST_REJECT;
        end else if (payload_remaining_reg != '0) begin
            result.status          = lpd_pkg::ST_PAYLOAD;
            result.payload_byte    = data_byte;
            payload_remaining_next = payload_remaining_reg - REM_ONE;
            if (payload_remaining_reg == REM_ONE) begin
                result.last         = 1'b1;
                result.frame_length = length_shift_reg[lpd_pkg::FLEN_W-1:0];
                header_count_next   = '0;
                length_shift_next   = '0;
            end
        end else begin
            length_shift_next = {length_shift_reg[lpd_pkg::LEN_W-9:0], data_byte};
            if (header_count_reg == 2'd3) begin
                // fourth header byte: length complete
                header_count_next = '0;
                if (length_shift_next == '0 || length_shift_next > LEN_LIMIT) begin
                    result.status   = lpd_pkg::ST_BADLEN;
                    error_flag_next = 1'b1;
                end else begin
                    payload_remaining_next = length_shift_next[REM_W-1:0];
                end
            end else begin
                header_count_next = header_count_reg + 2'd1;
            end
        end
    end

endmodule

// ----- rtl/core/lpd_out_reg.sv -----
// ----------------------------------------------------------------------------
// lpd_out_reg
// Result register with valid/ready handshake toward the sink.
// ----------------------------------------------------------------------------
module lpd_out_reg (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      load,
    input  lpd_pkg::lpd_result_t      result,
    output logic                      can_load,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [1:0]                m_status,
    output logic [7:0]                m_payload_byte,
    output logic                      m_last,
    output logic [lpd_pkg::FLEN_W-1:0] m_frame_length
);

    logic                 valid_reg;
    lpd_pkg::lpd_result_t result_reg;

    // slot frees up in the same cycle the sink takes the word
    assign can_load = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result;
        end
    end

    assign m_valid        = valid_reg;
    assign m_status       = result_reg.status;
    assign m_payload_byte = result_reg.payload_byte;
    assign m_last         = result_reg.last;
    assign m_frame_length = result_reg.frame_length;

endmodule

// ----- rtl/core/length_prefix_deframer_top.sv -----
// Result: registered; the result word is valid in the cycle after its input word is accepted.
// Throughput: 1 word per cycle while the sink is ready; set by the single result register, which
//   reloads in the same cycle the sink takes its word.
// Reset: aresetn is synchronous, active low; clears the header count, length,
//   payload count, error flag and the result valid. No clearing pass.
// ----------------------------------------------------------------------------
// length_prefix_deframer_top
// Deframes a byte stream carrying 32-bit big-endian length prefixes.
// ----------------------------------------------------------------------------
module length_prefix_deframer_top #(
    parameter int MAX_FRAME_BYTES = lpd_pkg::DEFAULT_MAX_FRAME_BYTES
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // input word channel
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_kind,
    input  logic [7:0]                 s_data_byte,
    // result word channel
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [1:0]                 m_status,
    output logic [7:0]                 m_payload_byte,
    output logic                       m_last,
    output logic [lpd_pkg::FLEN_W-1:0] m_frame_length
);

    logic                 accept;
    logic                 can_load;
    lpd_pkg::lpd_result_t result;

    // Every input word yields exactly one result word, so a word is taken
    // whenever the result register has room (empty, or draining this cycle).
    assign s_ready = can_load;
    assign accept  = s_valid && can_load;

    // Decoder: header assembly, length check, payload countdown, sticky error.
    // State advances only on an accepted word.
    lpd_decoder #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) u_decoder (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .kind      (s_kind),
        .data_byte (s_data_byte),
        .result    (result)
    );

    // Result register: holds the word until the sink takes it.
    lpd_out_reg u_out_reg (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .load           (accept),
        .result         (result),
        .can_load       (can_load),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_payload_byte (m_payload_byte),
        .m_last         (m_last),
        .m_frame_length (m_frame_length)
    );

endmodule
